FILE: rtl/aabbq_pkg.sv
// Package: shared types and codes of the box query pipeline
package aabbq_pkg;

    localparam int unsigned CoordW = 32;
    localparam int unsigned RadW   = 31;
    localparam int unsigned IdxW   = 3;

    // query kinds
    localparam logic [1:0] FUNC_BOX    = 2'd0;
    localparam logic [1:0] FUNC_RAY    = 2'd1;
    localparam logic [1:0] FUNC_SPHERE = 2'd2;
    localparam logic [1:0] FUNC_POINT  = 2'd3;

    // register indexes
    localparam logic [IdxW-1:0] REG_MIN_X = 3'd0;
    localparam logic [IdxW-1:0] REG_MIN_Y = 3'd1;
    localparam logic [IdxW-1:0] REG_MIN_Z = 3'd2;
    localparam logic [IdxW-1:0] REG_MAX_X = 3'd3;
    localparam logic [IdxW-1:0] REG_MAX_Y = 3'd4;
    localparam logic [IdxW-1:0] REG_MAX_Z = 3'd5;

    typedef struct packed {
        logic [1:0]               func;
        logic signed [CoordW-1:0] first_x;
        logic signed [CoordW-1:0] first_y;
        logic signed [CoordW-1:0] first_z;
        logic signed [CoordW-1:0] second_x;
        logic signed [CoordW-1:0] second_y;
        logic signed [CoordW-1:0] second_z;
        logic [RadW-1:0]          radius;
    } t_query;

    typedef struct packed {
        logic                     hit;
        logic signed [CoordW-1:0] ray_length;
    } t_result;

    typedef struct packed {
        logic [2:0][CoordW-1:0] lo;
        logic [2:0][CoordW-1:0] hi;
    } t_box;

    // after stage 1: differences and compare flags
    typedef struct packed {
        logic                   valid;
        logic [1:0]             func;
        logic                   bp_hit;
        logic [2:0][CoordW:0]   d_lo;
        logic [2:0][CoordW:0]   d_hi;
        logic [2:0][CoordW-1:0] inv;
        logic [2:0][CoordW-1:0] sph_d;
        logic [RadW-1:0]        radius;
    } t_s1;

    // after stage 2: raw products
    typedef struct packed {
        logic                     valid;
        logic [1:0]               func;
        logic                     bp_hit;
        logic [2:0][2*CoordW:0]   p_lo;
        logic [2:0][2*CoordW:0]   p_hi;
        logic [2:0][2*CoordW-1:0] sq;
        logic [2*RadW-1:0]        rsq;
    } t_s2;

    // after stage 3: ordered slabs and sphere flag
    typedef struct packed {
        logic                   valid;
        logic [1:0]             func;
        logic                   bp_hit;
        logic                   sph_hit;
        logic [2:0][CoordW-1:0] lo;
        logic [2:0][CoordW-1:0] hi;
    } t_s3;

endpackage

FILE: rtl/aabbq_front.sv
// Stage 1: corner differences, sphere distances and box/point compares
module aabbq_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  aabbq_pkg::t_query i_query,
    input  aabbq_pkg::t_box   i_box,
    output aabbq_pkg::t_s1    o_s1
);

    aabbq_pkg::t_s1 r_s1;
    aabbq_pkg::t_s1 n_s1;

    always_comb begin
        logic signed [31:0] a [3];
        logic signed [31:0] b [3];
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic box_ok;
        logic pt_ok;
        a[0] = i_query.first_x;
        a[1] = i_query.first_y;
        a[2] = i_query.first_z;
        b[0] = i_query.second_x;
        b[1] = i_query.second_y;
        b[2] = i_query.second_z;
        box_ok = 1'b1;
        pt_ok  = 1'b1;
        n_s1.valid  = i_valid;
        n_s1.func   = i_query.func;
        n_s1.radius = i_query.radius;
        for (int i = 0; i < 3; i++) begin
            lo = $signed(i_box.lo[i]);
            hi = $signed(i_box.hi[i]);
            // slab differences, 33 bits
            n_s1.d_lo[i] = 33'($signed({lo[31], lo}) - $signed({a[i][31], a[i]}));
            n_s1.d_hi[i] = 33'($signed({hi[31], hi}) - $signed({a[i][31], a[i]}));
            n_s1.inv[i]  = b[i];
            // distance to the nearest face, zero inside the slab
            if (a[i] < lo) begin
                n_s1.sph_d[i] = 32'(33'($signed({lo[31], lo}) - $signed({a[i][31], a[i]})));
            end else if (a[i] > hi) begin
                n_s1.sph_d[i] = 32'(33'($signed({a[i][31], a[i]}) - $signed({hi[31], hi})));
            end else begin
                n_s1.sph_d[i] = '0;
            end
            if (!(hi > a[i] && lo < b[i])) box_ok = 1'b0;
            if (!(a[i] > lo && a[i] < hi)) pt_ok = 1'b0;
        end
        n_s1.bp_hit = (i_query.func == aabbq_pkg::FUNC_BOX) ? box_ok : pt_ok;
    end

    // advance stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

FILE: rtl/aabbq_mul.sv
// Stage 2: slab products and squared distances
module aabbq_mul (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  aabbq_pkg::t_s1 i_s1,
    output aabbq_pkg::t_s2 o_s2
);

    aabbq_pkg::t_s2 r_s2;
    aabbq_pkg::t_s2 n_s2;

    always_comb begin
        logic signed [64:0] pl;
        logic signed [64:0] ph;
        n_s2.valid  = i_s1.valid;
        n_s2.func   = i_s1.func;
        n_s2.bp_hit = i_s1.bp_hit;
        for (int i = 0; i < 3; i++) begin
            pl = $signed(i_s1.d_lo[i]) * $signed(i_s1.inv[i]);
            ph = $signed(i_s1.d_hi[i]) * $signed(i_s1.inv[i]);
            n_s2.p_lo[i] = pl;
            n_s2.p_hi[i] = ph;
            n_s2.sq[i]   = 64'(i_s1.sph_d[i]) * 64'(i_s1.sph_d[i]);
        end
        n_s2.rsq = 62'(i_s1.radius) * 62'(i_s1.radius);
    end

    // advance stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
        end else begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;

endmodule

FILE: rtl/aabbq_post.sv
// Stage 3: scale and saturate products, order slabs, sum sphere distances
module aabbq_post (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  aabbq_pkg::t_s2 i_s2,
    output aabbq_pkg::t_s3 o_s3
);

    aabbq_pkg::t_s3 r_s3;
    aabbq_pkg::t_s3 n_s3;

    // floor shift by 16, clamp to signed 32 bits
    function automatic logic [31:0] sat_slab(input logic [64:0] p);
        logic signed [64:0] s;
        s = $signed(p) >>> 16;
        if (s > 65'sd2147483647) begin
            sat_slab = 32'h7FFF_FFFF;
        end else if (s < -65'sd2147483648) begin
            sat_slab = 32'h8000_0000;
        end else begin
            sat_slab = s[31:0];
        end
    endfunction

    // truncating shift by 16, clamp to 0x7FFFFFFF
    function automatic logic [30:0] sat_sq(input logic [63:0] p);
        logic [47:0] s;
        s = p[63:16];
        if (|s[47:31]) begin
            sat_sq = 31'h7FFF_FFFF;
        end else begin
            sat_sq = s[30:0];
        end
    endfunction

    always_comb begin
        logic signed [31:0] t0;
        logic signed [31:0] t1;
        logic signed [33:0] acc;
        n_s3.valid  = i_s2.valid;
        n_s3.func   = i_s2.func;
        n_s3.bp_hit = i_s2.bp_hit;
        acc = $signed({3'b000, sat_sq({2'b00, i_s2.rsq})});
        for (int i = 0; i < 3; i++) begin
            t0 = $signed(sat_slab(i_s2.p_lo[i]));
            t1 = $signed(sat_slab(i_s2.p_hi[i]));
            n_s3.lo[i] = (t0 < t1) ? t0 : t1;
            n_s3.hi[i] = (t0 < t1) ? t1 : t0;
            acc = acc - $signed({3'b000, sat_sq(i_s2.sq[i])});
        end
        n_s3.sph_hit = (acc > 34'sd0);
    end

    // advance stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3 <= '0;
        end else begin
            r_s3 <= n_s3;
        end
    end

    assign o_s3 = r_s3;

endmodule

FILE: rtl/aabb_collision_query_top.sv
// Top level: box registers, four-stage query pipeline and result register
//
// Usage: write the six box corners through i_cfg_we/i_cfg_idx/i_cfg_data
// (index 0..2 lower corner x,y,z, 3..5 upper corner x,y,z, signed Q16.16)
// while no query is in flight. Writes to other indexes are ignored.
// Present a query on i_query with start high; it is taken at that clock
// edge whenever busy is low. busy is never raised, so a query is taken
// every cycle that start is high.
// Each query yields one result on o_result, marked by o_valid for one
// cycle; the query passes through the stages in order before the result
// register loads (stages: differences, multipliers, scale and slab
// ordering, slab combine). Throughput is one query per cycle, set by the
// fully pipelined multipliers.
// The receiver cannot stall: a result must be taken in its cycle.
// Reset (synchronous, active low) clears the box to zero and drops all
// queries in flight; no result appears for them.
module aabb_collision_query_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  aabbq_pkg::t_query                 i_query,
    input  logic                              i_cfg_we,
    input  logic [aabbq_pkg::IdxW-1:0]        i_cfg_idx,
    input  logic [aabbq_pkg::CoordW-1:0]      i_cfg_data,
    output logic                              o_valid,
    output aabbq_pkg::t_result                o_result
);

    aabbq_pkg::t_box    r_box;
    aabbq_pkg::t_s1     s1;
    aabbq_pkg::t_s2     s2;
    aabbq_pkg::t_s3     s3;
    aabbq_pkg::t_result n_result;
    aabbq_pkg::t_result r_result;
    logic               r_valid;
    logic [1:0]         r_func;

    assign busy = 1'b0;

    // hold box registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                aabbq_pkg::REG_MIN_X: r_box.lo[0] <= i_cfg_data;
                aabbq_pkg::REG_MIN_Y: r_box.lo[1] <= i_cfg_data;
                aabbq_pkg::REG_MIN_Z: r_box.lo[2] <= i_cfg_data;
                aabbq_pkg::REG_MAX_X: r_box.hi[0] <= i_cfg_data;
                aabbq_pkg::REG_MAX_Y: r_box.hi[1] <= i_cfg_data;
                aabbq_pkg::REG_MAX_Z: r_box.hi[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    aabbq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_query (i_query),
        .i_box   (r_box),
        .o_s1    (s1)
    );

    aabbq_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s1    (s1),
        .o_s2    (s2)
    );

    aabbq_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s2    (s2),
        .o_s3    (s3)
    );

    // combine slabs y then z into the x interval, pick the result
    always_comb begin
        logic signed [31:0] tmin;
        logic signed [31:0] tmax;
        logic signed [31:0] len;
        logic               ray_hit;
        tmin    = $signed(s3.lo[0]);
        tmax    = $signed(s3.hi[0]);
        ray_hit = 1'b1;
        len     = '0;
        for (int i = 1; i < 3; i++) begin
            if (ray_hit) begin
                if (tmin > $signed(s3.hi[i]) || $signed(s3.lo[i]) > tmax) begin
                    ray_hit = 1'b0;
                    len     = tmin;
                end else begin
                    if ($signed(s3.lo[i]) > tmin) tmin = $signed(s3.lo[i]);
                    if ($signed(s3.hi[i]) < tmax) tmax = $signed(s3.hi[i]);
                end
            end
        end
        if (ray_hit) len = tmax;
        unique case (s3.func)
            aabbq_pkg::FUNC_RAY: begin
                n_result.hit        = ray_hit;
                n_result.ray_length = len;
            end
            aabbq_pkg::FUNC_SPHERE: begin
                n_result.hit        = s3.sph_hit;
                n_result.ray_length = '0;
            end
            default: begin
                n_result.hit        = s3.bp_hit;
                n_result.ray_length = '0;
            end
        endcase
    end

    // drive result register
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        r_func   <= s3.func;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= s3.valid;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    // every item leaving stage 3 is delivered in the next cycle
    a_deliver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s3.valid |=> o_valid)
        else $error("item lost at the output register");

    // an accepted item reaches stage 1
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> s1.valid)
        else $error("accepted item missing in stage 1");

    // non-ray results carry zero length
    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_func != aabbq_pkg::FUNC_RAY) |-> (o_result.ray_length == '0))
        else $error("non-ray result with nonzero length");

    // reset drops results
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown after reset");

endmodule

FILE: verif/testbench.sv
// Testbench: box query unit vs predictor and typed rows, directed table then random queries
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam logic signed [31:0] S_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] S_MIN = 32'sh80000000;
    localparam logic signed [31:0] ONE = 32'sh00010000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    aabbq_pkg::t_query  i_query;
    logic        i_cfg_we;
    logic [aabbq_pkg::IdxW-1:0]   i_cfg_idx;
    logic [aabbq_pkg::CoordW-1:0] i_cfg_data;
    logic        o_valid;
    aabbq_pkg::t_result o_result;

    aabb_collision_query_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_query(i_query), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .o_valid(o_valid), .o_result(o_result)
    );

    // predictor copy of the box
    logic signed [31:0] box_lo [3];
    logic signed [31:0] box_hi [3];

    aabbq_pkg::t_result pending_results [$];
    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned idle_pct;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    function automatic logic signed [31:0] sat_shift(input logic signed [65:0] p);
        logic signed [65:0] s;
        s = p >>> 16;
        if (s > 66'sd2147483647) return S_MAX;
        if (s < -66'sd2147483648) return S_MIN;
        return s[31:0];
    endfunction

    function automatic logic signed [31:0] slab_dist(input logic signed [31:0] corner,
            input logic signed [31:0] org, input logic signed [31:0] inv);
        logic signed [32:0] d;
        logic signed [65:0] p;
        d = 33'(corner) - 33'(org);
        p = 66'(d) * 66'(inv);
        return sat_shift(p);
    endfunction

    function automatic logic [31:0] square_sat(input logic signed [32:0] d);
        logic [32:0] a;
        logic [65:0] s;
        a = d < 0 ? 33'(-d) : 33'(d);
        s = (66'(a) * 66'(a)) >> 16;
        if (s > 66'h7FFFFFFF) return 32'h7FFFFFFF;
        return s[31:0];
    endfunction

    function automatic aabbq_pkg::t_result predict_query(input aabbq_pkg::t_query q);
        aabbq_pkg::t_result r;
        logic signed [31:0] a [3], b [3], lo [3], hi [3], t0, t1, tmin, tmax;
        logic signed [35:0] acc;
        r.hit = 1'b1;
        r.ray_length = '0;
        a = '{q.first_x, q.first_y, q.first_z};
        b = '{q.second_x, q.second_y, q.second_z};
        case (q.func)
            aabbq_pkg::FUNC_BOX: begin
                for (int i = 0; i < 3; i++)
                    if (!(box_hi[i] > a[i] && box_lo[i] < b[i])) r.hit = 1'b0;
            end
            aabbq_pkg::FUNC_RAY: begin
                for (int i = 0; i < 3; i++) begin
                    t0 = slab_dist(box_lo[i], a[i], b[i]);
                    t1 = slab_dist(box_hi[i], a[i], b[i]);
                    lo[i] = t0 < t1 ? t0 : t1;
                    hi[i] = t0 < t1 ? t1 : t0;
                end
                tmin = lo[0];
                tmax = hi[0];
                for (int i = 1; i < 3; i++) begin
                    if (r.hit) begin
                        if (tmin > hi[i] || lo[i] > tmax) begin
                            r.hit = 1'b0;
                            r.ray_length = tmin;
                        end else begin
                            if (lo[i] > tmin) tmin = lo[i];
                            if (hi[i] < tmax) tmax = hi[i];
                        end
                    end
                end
                if (r.hit) r.ray_length = tmax;
            end
            aabbq_pkg::FUNC_SPHERE: begin
                acc = 36'(square_sat(33'(q.radius)));
                for (int i = 0; i < 3; i++) begin
                    if (a[i] < box_lo[i])
                        acc -= 36'(square_sat(33'(a[i]) - 33'(box_lo[i])));
                    else if (a[i] > box_hi[i])
                        acc -= 36'(square_sat(33'(a[i]) - 33'(box_hi[i])));
                end
                r.hit = acc > 0;
            end
            default: begin
                for (int i = 0; i < 3; i++)
                    if (!(a[i] > box_lo[i] && a[i] < box_hi[i])) r.hit = 1'b0;
            end
        endcase
        return r;
    endfunction

    // check each result against the oldest expectation
    always @(posedge i_clk) begin
        aabbq_pkg::t_result want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                want = pending_results.pop_front();
                if (o_result.hit !== want.hit)
                    report_mismatch($sformatf("hit %b want %b", o_result.hit, want.hit));
                if (o_result.ray_length !== want.ray_length)
                    report_mismatch($sformatf("ray_length %h want %h",
                        o_result.ray_length, want.ray_length));
            end
        end
    end

    // timeout guard
    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL aabb_collision_query_top");
            $finish;
        end
    end

    task automatic write_box(input logic [aabbq_pkg::IdxW-1:0] idx,
            input logic signed [31:0] v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        if (idx < 3) box_lo[idx] = v;
        else box_hi[idx - 3] = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_box(input logic signed [31:0] lx, ly, lz, hx, hy, hz);
        write_box(aabbq_pkg::REG_MIN_X, lx);
        write_box(aabbq_pkg::REG_MIN_Y, ly);
        write_box(aabbq_pkg::REG_MIN_Z, lz);
        write_box(aabbq_pkg::REG_MAX_X, hx);
        write_box(aabbq_pkg::REG_MAX_Y, hy);
        write_box(aabbq_pkg::REG_MAX_Z, hz);
    endtask

    // stop sending, drain in-flight items before touching the box
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // present one item, with random sender idling beforehand; start stays
    // high on return so the next item can follow with no gap
    task automatic send_query(input aabbq_pkg::t_query q, input aabbq_pkg::t_result want,
            input bit typed);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start   <= 1'b1;
        i_query <= q;
        pending_results.push_back(typed ? want : predict_query(q));
        do @(posedge i_clk); while (busy);
    endtask

    function automatic logic signed [31:0] rand_coord(input int unsigned mode);
        case (mode)
            0: return $signed($urandom());
            1: return $signed($urandom_range(8 * 65536)) - 32'sd262144;
            2: return $urandom_range(1) ? S_MAX : S_MIN;
            default: return $signed($urandom_range(400)) - 32'sd200;
        endcase
    endfunction

    function automatic aabbq_pkg::t_query rand_query(input int unsigned mode);
        aabbq_pkg::t_query q;
        q.func     = 2'($urandom_range(3));
        q.first_x  = rand_coord(mode == 0 ? $urandom_range(3) : mode);
        q.first_y  = rand_coord(mode == 0 ? $urandom_range(3) : mode);
        q.first_z  = rand_coord(mode == 0 ? $urandom_range(3) : mode);
        q.second_x = rand_coord(mode == 0 ? $urandom_range(3) : mode);
        q.second_y = rand_coord(mode == 0 ? $urandom_range(3) : mode);
        q.second_z = rand_coord(mode == 0 ? $urandom_range(3) : mode);
        q.radius   = $urandom_range(1) ? 31'($urandom()) : 31'($urandom_range(6 * 65536));
        if (q.func == aabbq_pkg::FUNC_RAY && $urandom_range(7) == 0) q.second_y = '0;
        return q;
    endfunction

    typedef struct {
        aabbq_pkg::t_query  q;
        bit                 typed;
        aabbq_pkg::t_result want;
    } t_stim_row;

    t_stim_row stim_table [$];

    function automatic aabbq_pkg::t_query mkq(input logic [1:0] f,
            input logic signed [31:0] ax, ay, az, bx, by, bz, input logic [30:0] rad);
        aabbq_pkg::t_query q;
        q = '{f, ax, ay, az, bx, by, bz, rad};
        return q;
    endfunction

    initial begin
        aabbq_pkg::t_query q;
        error_count = 0;
        cycle_count = 0;
        idle_pct    = 9;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_query = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        for (int i = 0; i < 3; i++) begin
            box_lo[i] = '0;
            box_hi[i] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero box after reset: the point test fails, rays see zero slabs
        stim_table.push_back('{mkq(aabbq_pkg::FUNC_POINT, 0, 0, 0, 0, 0, 0, 0),
            1, '{1'b0, 32'sd0}});
        stim_table.push_back('{mkq(aabbq_pkg::FUNC_BOX, S_MIN, S_MIN, S_MIN,
            S_MAX, S_MAX, S_MAX, 0), 1, '{1'b1, 32'sd0}});
        stim_table.push_back('{mkq(aabbq_pkg::FUNC_RAY, 0, 0, 0, 0, 0, 0, 0),
            1, '{1'b1, 32'sd0}});
        stim_table.push_back('{mkq(aabbq_pkg::FUNC_SPHERE, 0, 0, 0, 0, 0, 0, 0),
            1, '{1'b0, 32'sd0}});
        stim_table.push_back('{mkq(aabbq_pkg::FUNC_SPHERE, 0, 0, 0, 0, 0, 0, 31'h7FFFFFFF),
            1, '{1'b1, 32'sd0}});
        foreach (stim_table[i])
            send_query(stim_table[i].q, stim_table[i].want, stim_table[i].typed);
        wait_idle();

        // unit box: predictor checks the remaining directed rows
        stim_table.delete();
        set_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
        stim_table.push_back('{mkq(aabbq_pkg::FUNC_POINT, 0, 0, 0, 0, 0, 0, 0),
            0, '{0, 0}});
        stim_table.push_back('{mkq(aabbq_pkg::FUNC_POINT, ONE, 0, 0, 0, 0, 0, 0),
            0, '{0, 0}});
        stim_table.push_back('{mkq(aabbq_pkg::FUNC_BOX, ONE, 0, 0, 2 * ONE, ONE, ONE, 0),
            0, '{0, 0}});
        stim_table.push_back('{mkq(aabbq_pkg::FUNC_BOX, 0, 0, 0, 2 * ONE, ONE, ONE, 0),
            0, '{0, 0}});
        stim_table.push_back('{mkq(aabbq_pkg::FUNC_RAY, -4 * ONE, 0, 0, ONE, 0, 0, 0),
            0, '{0, 0}});
        stim_table.push_back('{mkq(aabbq_pkg::FUNC_RAY, 4 * ONE, 0, 0, -ONE, 0, 0, 0),
            0, '{0, 0}});
        stim_table.push_back('{mkq(aabbq_pkg::FUNC_RAY, -4 * ONE, 3 * ONE, 0,
            ONE, ONE, ONE, 0), 0, '{0, 0}});
        stim_table.push_back('{mkq(aabbq_pkg::FUNC_RAY, S_MIN, S_MAX, S_MIN,
            S_MAX, S_MIN, S_MAX, 0), 0, '{0, 0}});
        stim_table.push_back('{mkq(aabbq_pkg::FUNC_SPHERE, 2 * ONE, 0, 0, 0, 0, 0,
            31'(ONE)), 0, '{0, 0}});
        stim_table.push_back('{mkq(aabbq_pkg::FUNC_SPHERE, 2 * ONE, 0, 0, 0, 0, 0,
            31'(ONE + 1)), 0, '{0, 0}});
        stim_table.push_back('{mkq(aabbq_pkg::FUNC_SPHERE, S_MIN, S_MAX, S_MIN, 0, 0, 0,
            31'h7FFFFFFF), 0, '{0, 0}});
        foreach (stim_table[i])
            send_query(stim_table[i].q, stim_table[i].want, stim_table[i].typed);
        wait_idle();

        // inverted box, then extreme box
        set_box(ONE, ONE, ONE, -ONE, -ONE, -ONE);
        for (int n = 0; n < 100; n++) send_query(rand_query($urandom_range(3)), '{0, 0}, 0);
        wait_idle();
        set_box(S_MIN, S_MIN, S_MIN, S_MAX, S_MAX, S_MAX);
        for (int n = 0; n < 100; n++) send_query(rand_query($urandom_range(3)), '{0, 0}, 0);
        wait_idle();

        // random phases: sender idles 9%, then 70%, then never
        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = ph == 0 ? 9 : (ph == 1 ? 70 : 0);
            for (int s = 0; s < 2; s++) begin
                set_box(rand_coord(1), rand_coord(1), rand_coord(1),
                        rand_coord(1), rand_coord(1), rand_coord(1));
                if ($urandom_range(1)) begin
                    write_box(aabbq_pkg::REG_MIN_X,
                        -$signed(32'($urandom_range(3 * 65536))));
                    write_box(aabbq_pkg::REG_MAX_X, 32'($urandom_range(3 * 65536)));
                end
                for (int n = 0; n < 150; n++) begin
                    q = rand_query($urandom_range(3) == 0 ? 0 : 1);
                    send_query(q, '{0, 0}, 0);
                end
                wait_idle();
            end
            set_box(rand_coord(0), rand_coord(0), rand_coord(0),
                    rand_coord(0), rand_coord(0), rand_coord(0));
            for (int n = 0; n < 30; n++) send_query(rand_query(0), '{0, 0}, 0);
            wait_idle();
        end

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS aabb_collision_query_top");
        end else begin
            $display("FAIL aabb_collision_query_top");
        end
        $finish;
    end
endmodule
